>>> hw/rtl/psl_pkg.sv
// Shared types, widths and codes for the parent-set score lookup block.
package psl_pkg;

  // Default sizing
  localparam int PSL_MAX_NODES   = 16;
  localparam int PSL_MAX_ENTRIES = 64;
  localparam int PSL_SCORE_W     = 48;
  localparam int PSL_QUEUE_DEPTH = 2;

  // Fixed field widths of the channels
  localparam int OP_W   = 2;
  localparam int NODE_W = 4;
  localparam int SLOT_W = 6;
  localparam int ECNT_W = 7;
  localparam int MASK_W = 16;
  localparam int NC_W   = 5;

  localparam logic [NC_W-1:0] NC_RESET = 5'd16;

  // Operation codes carried by an input transaction
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_COUNT  = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  // Command kinds handed from the front end to the back end
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_NOP    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COUNT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              first;
    logic              node_ok;
  } cmd_ctl_t;

  // Command layout at the default sizing
  typedef struct packed {
    cmd_ctl_t                 ctl;
    logic [3:0]               node_idx;
    logic [9:0]               addr;
    logic [6:0]               cnt;
    logic [MASK_W-1:0]        cmask;
    logic [MASK_W-1:0]        pmask;
    logic signed [PSL_SCORE_W-1:0] score;
  } psl_cmd_t;

endpackage

>>> hw/rtl/psl_ifs.sv
// Valid/ready channel interfaces for the input items and the results.
interface psl_in_if #(
  parameter int SCORE_WIDTH = psl_pkg::PSL_SCORE_W
);
  import psl_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [OP_W-1:0]               operation;
  logic [NODE_W-1:0]             node;
  logic [SLOT_W-1:0]             slot;
  logic [ECNT_W-1:0]             entry_count;
  logic [MASK_W-1:0]             parent_mask;
  logic signed [SCORE_WIDTH-1:0] entry_score;
  logic                          first_node;

  modport source (output valid, operation, node, slot, entry_count, parent_mask,
                  entry_score, first_node, input ready);
  modport sink   (input valid, operation, node, slot, entry_count, parent_mask,
                  entry_score, first_node, output ready);
endinterface

interface psl_out_if #(
  parameter int SCORE_WIDTH = psl_pkg::PSL_SCORE_W
);
  import psl_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [SLOT_W-1:0]             location;
  logic signed [SCORE_WIDTH-1:0] node_score;
  logic signed [SCORE_WIDTH-1:0] network_score;

  modport source (output valid, found, location, node_score, network_score,
                  input ready);
  modport sink   (input valid, found, location, node_score, network_score,
                  output ready);
endinterface

>>> hw/rtl/psl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module psl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/psl_fifo.sv
// Small command queue between the front end and the back end.
module psl_fifo #(
  parameter type cmd_t = psl_pkg::psl_cmd_t,
  parameter int  DEPTH = psl_pkg::PSL_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output cmd_t pop_data,
  output logic full,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  cmd_t          slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FW-1:0] fill_r, fill_nxt;

  assign full     = (fill_r == FW'(DEPTH));
  assign empty    = (fill_r == '0);
  assign pop_data = slots_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hw/rtl/psl_front.sv
// Front end: takes input transactions, decodes and range-checks them into commands.
module psl_front #(
  parameter type cmd_t          = psl_pkg::psl_cmd_t,
  parameter int  MAX_NODES      = psl_pkg::PSL_MAX_NODES,
  parameter int  MAX_ENTRIES_PER_NODE = psl_pkg::PSL_MAX_ENTRIES,
  parameter int  SCORE_WIDTH    = psl_pkg::PSL_SCORE_W
) (
  input  logic                      clk,
  input  logic                      rst_n,
  psl_in_if.sink                    in_chan,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [psl_pkg::NC_W-1:0]  cfg_data,
  input  logic                      q_full,
  output logic                      q_push,
  output cmd_t                      q_cmd
);
  import psl_pkg::*;

  localparam int NCNT   = (MAX_NODES < 16) ? MAX_NODES : 16;
  localparam int NIDX_W = $clog2(NCNT);
  localparam int ROWS   = NCNT * MAX_ENTRIES_PER_NODE;
  localparam int ROW_AW = $clog2(ROWS);
  localparam int CNT_W  = $clog2(MAX_ENTRIES_PER_NODE + 1);

  logic [NC_W-1:0]   node_count_r;
  logic              node_ok;
  logic              slot_ok;
  logic [ROW_AW-1:0] row_base;
  logic [CNT_W-1:0]  cnt_sat;
  logic [MASK_W-1:0] cmask;

  // Node count register; users send writes only while the block is idle (unchecked)
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NC_RESET;
    end else if (cfg_valid) begin
      node_count_r <= cfg_data;
    end
  end

  // Accept whenever the queue has room
  assign in_chan.ready = !q_full;
  assign q_push        = in_chan.valid && !q_full;

  // Range checks and derived values
  assign node_ok  = (int'(in_chan.node) < MAX_NODES);
  assign slot_ok  = (int'(in_chan.slot) < MAX_ENTRIES_PER_NODE);
  assign row_base = ROW_AW'(NIDX_W'(in_chan.node)) * ROW_AW'(MAX_ENTRIES_PER_NODE);
  assign cnt_sat  = (int'(in_chan.entry_count) > MAX_ENTRIES_PER_NODE) ?
                    CNT_W'(MAX_ENTRIES_PER_NODE) : CNT_W'(in_chan.entry_count);
  assign cmask    = (node_count_r >= NC_W'(MASK_W)) ? '1 :
                    ((MASK_W'(1) << node_count_r) - MASK_W'(1));

  // Command build
  always_comb begin
    q_cmd             = '0;
    q_cmd.ctl.first   = in_chan.first_node;
    q_cmd.ctl.node_ok = node_ok;
    q_cmd.node_idx    = NIDX_W'(in_chan.node);
    q_cmd.cnt         = cnt_sat;
    q_cmd.cmask       = cmask;
    q_cmd.pmask       = in_chan.parent_mask;
    q_cmd.score       = in_chan.entry_score;
    q_cmd.addr        = row_base;
    case (in_chan.operation)
      OP_LOAD: begin
        if (node_ok && slot_ok) begin
          q_cmd.ctl.kind = KIND_WRITE;
          q_cmd.addr     = row_base + ROW_AW'(in_chan.slot);
        end else begin
          q_cmd.ctl.kind = KIND_NOP;
        end
      end
      OP_COUNT: begin
        q_cmd.ctl.kind = node_ok ? KIND_COUNT : KIND_NOP;
      end
      OP_LOOKUP: begin
        q_cmd.ctl.kind = KIND_LOOKUP;
      end
      default: begin
        q_cmd.ctl.kind = KIND_NOP;
      end
    endcase
  end

endmodule

>>> hw/rtl/psl_back.sv
// Back end: executes commands, scans the score cache and keeps the network total.
module psl_back #(
  parameter type cmd_t          = psl_pkg::psl_cmd_t,
  parameter int  MAX_NODES      = psl_pkg::PSL_MAX_NODES,
  parameter int  MAX_ENTRIES_PER_NODE = psl_pkg::PSL_MAX_ENTRIES,
  parameter int  SCORE_WIDTH    = psl_pkg::PSL_SCORE_W
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  psl_out_if.source out_chan
);
  import psl_pkg::*;

  localparam int NCNT   = (MAX_NODES < 16) ? MAX_NODES : 16;
  localparam int ROWS   = NCNT * MAX_ENTRIES_PER_NODE;
  localparam int ROW_AW = $clog2(ROWS);
  localparam int CNT_W  = $clog2(MAX_ENTRIES_PER_NODE + 1);
  localparam int ROW_W  = MASK_W + SCORE_WIDTH;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_ACC  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic signed [SCORE_WIDTH-1:0] SCORE_MAX = {1'b0, {(SCORE_WIDTH-1){1'b1}}};
  localparam logic signed [SCORE_WIDTH-1:0] SCORE_MIN = {1'b1, {(SCORE_WIDTH-1){1'b0}}};

  logic [1:0]                    st_r, st_nxt;
  cmd_t                          cur_r, cur_nxt;
  logic [CNT_W-1:0]              cnt_mem_r [NCNT];
  logic [CNT_W-1:0]              cnt_mem_nxt [NCNT];
  logic signed [SCORE_WIDTH-1:0] total_r, total_nxt;
  logic [CNT_W-1:0]              scan_cnt_r, scan_cnt_nxt;
  logic [CNT_W-1:0]              rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]              cmp_idx_r, cmp_idx_nxt;
  logic                          cmp_vld_r, cmp_vld_nxt;
  logic                          hit_r, hit_nxt;
  logic [CNT_W-1:0]              loc_r, loc_nxt;
  logic signed [SCORE_WIDTH-1:0] hit_score_r, hit_score_nxt;

  logic                          out_vld_r, out_vld_nxt;
  logic                          out_found_r, out_found_nxt;
  logic [SLOT_W-1:0]             out_loc_r, out_loc_nxt;
  logic signed [SCORE_WIDTH-1:0] out_nscore_r, out_nscore_nxt;
  logic signed [SCORE_WIDTH-1:0] out_total_r, out_total_nxt;

  logic                          ram_we;
  logic [ROW_AW-1:0]             ram_raddr;
  logic [ROW_W-1:0]              ram_rdata;
  logic [MASK_W-1:0]             rd_mask;
  logic signed [SCORE_WIDTH-1:0] rd_score;
  logic                          row_match;
  logic                          rd_en;
  logic [CNT_W-1:0]              node_cnt;
  logic signed [SCORE_WIDTH:0]   acc_sum;

  // Score cache rows: mask in the upper bits, score below
  psl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_cmd.addr),
    .wdata ({q_cmd.pmask, q_cmd.score}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_raddr = cur_r.addr + ROW_AW'(rd_idx_r);
  assign rd_mask   = ram_rdata[ROW_W-1:SCORE_WIDTH];
  assign rd_score  = ram_rdata[SCORE_WIDTH-1:0];
  assign row_match = (((rd_mask ^ cur_r.pmask) & cur_r.cmask) == '0);
  assign node_cnt  = cnt_mem_r[q_cmd.node_idx];

  // Saturating accumulate, one guard bit
  assign acc_sum = {total_r[SCORE_WIDTH-1], total_r} +
                   {hit_score_r[SCORE_WIDTH-1], hit_score_r};

  // Sequencer
  always_comb begin
    st_nxt         = st_r;
    cur_nxt        = cur_r;
    cnt_mem_nxt    = cnt_mem_r;
    total_nxt      = total_r;
    scan_cnt_nxt   = scan_cnt_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = 1'b0;
    hit_nxt        = hit_r;
    loc_nxt        = loc_r;
    hit_score_nxt  = hit_score_r;
    out_vld_nxt    = out_vld_r && !out_chan.ready;
    out_found_nxt  = out_found_r;
    out_loc_nxt    = out_loc_r;
    out_nscore_nxt = out_nscore_r;
    out_total_nxt  = out_total_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    rd_en          = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cur_nxt = q_cmd;
          hit_nxt = 1'b0;
          st_nxt  = ST_DONE;
          case (q_cmd.ctl.kind)
            KIND_WRITE: begin
              ram_we = 1'b1;
            end
            KIND_COUNT: begin
              cnt_mem_nxt[q_cmd.node_idx] = q_cmd.cnt;
            end
            KIND_LOOKUP: begin
              if (q_cmd.ctl.first) begin
                total_nxt = '0;
              end
              if (q_cmd.ctl.node_ok && (node_cnt != '0)) begin
                scan_cnt_nxt = node_cnt;
                rd_idx_nxt   = '0;
                st_nxt       = ST_SCAN;
              end
            end
            KIND_NOP: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // one row read issued per cycle, compared when its data returns
        rd_en       = (rd_idx_r < scan_cnt_r);
        cmp_vld_nxt = rd_en;
        cmp_idx_nxt = rd_idx_r;
        if (rd_en) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        if (cmp_vld_r) begin
          if (row_match) begin
            hit_nxt       = 1'b1;
            loc_nxt       = cmp_idx_r;
            hit_score_nxt = rd_score;
            cmp_vld_nxt   = 1'b0;
            st_nxt        = ST_ACC;
          end else if (cmp_idx_r == scan_cnt_r - 1'b1) begin
            cmp_vld_nxt = 1'b0;
            st_nxt      = ST_DONE;
          end
        end
      end
      ST_ACC: begin
        if (acc_sum[SCORE_WIDTH] != acc_sum[SCORE_WIDTH-1]) begin
          total_nxt = acc_sum[SCORE_WIDTH] ? SCORE_MIN : SCORE_MAX;
        end else begin
          total_nxt = acc_sum[SCORE_WIDTH-1:0];
        end
        st_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_r || out_chan.ready) begin
          out_vld_nxt    = 1'b1;
          out_found_nxt  = hit_r;
          out_loc_nxt    = hit_r ? SLOT_W'(loc_r) : '0;
          out_nscore_nxt = hit_r ? hit_score_r : '0;
          out_total_nxt  = total_r;
          st_nxt         = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      cnt_mem_r <= '{default: '0};
      total_r   <= '0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      cnt_mem_r <= cnt_mem_nxt;
      total_r   <= total_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    scan_cnt_r   <= scan_cnt_nxt;
    rd_idx_r     <= rd_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    hit_r        <= hit_nxt;
    loc_r        <= loc_nxt;
    hit_score_r  <= hit_score_nxt;
    out_found_r  <= out_found_nxt;
    out_loc_r    <= out_loc_nxt;
    out_nscore_r <= out_nscore_nxt;
    out_total_r  <= out_total_nxt;
  end

  assign out_chan.valid         = out_vld_r;
  assign out_chan.found         = out_found_r;
  assign out_chan.location      = out_loc_r;
  assign out_chan.node_score    = out_nscore_r;
  assign out_chan.network_score = out_total_r;

endmodule

>>> hw/rtl/parent_set_score_lookup_core.sv
// Parent-set score lookup: top level joining front end, command queue and back end.
//
// Usage:
//   in_chan  - valid/ready channel of items: load a cache row, set a node's row
//              count, or look up a node's parent mask. One result per item.
//   out_chan - valid/ready channel of results: found, location, node_score and
//              the running network_score after the item.
//   cfg_*    - write channel for node_count (mask bits compared); cfg_ready is
//              always high. Write it only while no item is in flight.
// Timing: the back end runs one command at a time. A load or count update is
//   queued, popped in the idle state and sent to the output register from the
//   done state, and the next command is popped only once the back end is idle;
//   a lookup reads at most its node's valid rows through the single read port of
//   the row RAM (one row read per cycle, compared in the cycle after).
// The input side keeps taking items into a 2-deep command queue while the back
//   end works or while a result waits in the output register; a stalled
//   receiver holds the result and, once the queue fills, in_chan.ready drops.
// Reset clears all row counts, the running total and node_count to 16; the row RAM
//   is not cleared; the user must read a row only after it is written (unchecked).
module parent_set_score_lookup_core #(
  parameter int MAX_NODES            = psl_pkg::PSL_MAX_NODES,
  parameter int MAX_ENTRIES_PER_NODE = psl_pkg::PSL_MAX_ENTRIES,
  parameter int SCORE_WIDTH          = psl_pkg::PSL_SCORE_W
) (
  input  logic                     clk,
  input  logic                     rst_n,
  psl_in_if.sink                   in_chan,
  psl_out_if.source                out_chan,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [psl_pkg::NC_W-1:0] cfg_data
);
  import psl_pkg::*;

  localparam int NCNT   = (MAX_NODES < 16) ? MAX_NODES : 16;
  localparam int NIDX_W = $clog2(NCNT);
  localparam int ROW_AW = $clog2(NCNT * MAX_ENTRIES_PER_NODE);
  localparam int CNT_W  = $clog2(MAX_ENTRIES_PER_NODE + 1);

  typedef struct packed {
    cmd_ctl_t                      ctl;
    logic [NIDX_W-1:0]             node_idx;
    logic [ROW_AW-1:0]             addr;
    logic [CNT_W-1:0]              cnt;
    logic [MASK_W-1:0]             cmask;
    logic [MASK_W-1:0]             pmask;
    logic signed [SCORE_WIDTH-1:0] score;
  } cmd_t;

  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  // Decode and classify
  psl_front #(
    .cmd_t                (cmd_t),
    .MAX_NODES            (MAX_NODES),
    .MAX_ENTRIES_PER_NODE (MAX_ENTRIES_PER_NODE),
    .SCORE_WIDTH          (SCORE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  // Command queue
  psl_fifo #(
    .cmd_t (cmd_t),
    .DEPTH (PSL_QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_cmd),
    .pop       (q_pop),
    .pop_data  (pop_cmd),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Execute
  psl_back #(
    .cmd_t                (cmd_t),
    .MAX_NODES            (MAX_NODES),
    .MAX_ENTRIES_PER_NODE (MAX_ENTRIES_PER_NODE),
    .SCORE_WIDTH          (SCORE_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_cmd    (pop_cmd),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

>>> hw/rtl/psl_checker.sv
// Port-level checks on the lookup core, bound to the top level.
module psl_checker #(
  parameter int SCORE_WIDTH = psl_pkg::PSL_SCORE_W
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          found,
  input logic [psl_pkg::SLOT_W-1:0]    location,
  input logic signed [SCORE_WIDTH-1:0] node_score,
  input logic signed [SCORE_WIDTH-1:0] network_score
);

  logic       in_acc;
  logic       out_acc;
  logic [3:0] pend_r, pend_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Items accepted but not yet answered
  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(location) &&
                                $stable(node_score) && $stable(network_score))
    else $error("result changed while stalled");

  // Reset empties the output register
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A miss or a load reports no slot and no score
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found |-> (location == '0) && (node_score == '0))
    else $error("miss carries a location or score");

  // Every result answers an earlier accepted item
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pend_r != '0)
    else $error("result without a pending item");

endmodule

bind parent_set_score_lookup_core psl_checker #(
  .SCORE_WIDTH (SCORE_WIDTH)
) u_psl_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .found         (out_chan.found),
  .location      (out_chan.location),
  .node_score    (out_chan.node_score),
  .network_score (out_chan.network_score)
);
